// File: hdl/slew_lim_pkg.sv
package slew_lim_pkg;

	localparam int PAN_W   = 17;
	localparam int TILT_W  = 16;
	localparam int ZOOM_W  = 16;
	localparam int PSTEP_W = 16;
	localparam int TSTEP_W = 15;
	localparam int ZSTEP_W = 16;
	localparam int TOL_W   = 10;
	localparam int OP_W    = 3;
	localparam int CIDX_W  = 3;
	localparam int CDATA_W = 16;
	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 56;

	localparam logic [PSTEP_W-1:0] PAN_STEP_RST  = PSTEP_W'(100);
	localparam logic [TSTEP_W-1:0] TILT_STEP_RST = TSTEP_W'(100);
	localparam logic [ZSTEP_W-1:0] ZOOM_STEP_RST = ZSTEP_W'(100);
	localparam logic [TOL_W-1:0]   ANGLE_TOL_RST = TOL_W'(10);
	localparam logic [TOL_W-1:0]   ZOOM_TOL_RST  = TOL_W'(10);

	typedef enum logic [OP_W-1:0] {
		OP_TICK     = 3'd0,
		OP_SET_PAN  = 3'd1,
		OP_SET_TILT = 3'd2,
		OP_SET_ZOOM = 3'd3,
		OP_SET_ALL  = 3'd4,
		OP_STOP     = 3'd5
	} op_t;

	typedef enum logic [CIDX_W-1:0] {
		CFG_PAN_STEP  = 3'd0,
		CFG_TILT_STEP = 3'd1,
		CFG_ZOOM_STEP = 3'd2,
		CFG_ANGLE_TOL = 3'd3,
		CFG_ZOOM_TOL  = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [PSTEP_W-1:0] pan_step;
		logic [TSTEP_W-1:0] tilt_step;
		logic [ZSTEP_W-1:0] zoom_step;
		logic [TOL_W-1:0]   angle_tolerance;
		logic [TOL_W-1:0]   zoom_tolerance;
	} cfg_t;

	typedef struct packed {
		logic [OP_W-1:0]          op;
		logic signed [PAN_W-1:0]  pan_target;
		logic signed [TILT_W-1:0] tilt_target;
		logic [ZOOM_W-1:0]        zoom_target;
	} cmd_t;

	typedef struct packed {
		logic signed [PAN_W-1:0]  pan_now;
		logic signed [TILT_W-1:0] tilt_now;
		logic [ZOOM_W-1:0]        zoom_now;
		logic                     changed;
		logic                     is_moving;
		logic                     done_res;
	} res_t;

endpackage

// File: hdl/slew_lim_cfg_regs.sv
module slew_lim_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [slew_lim_pkg::CIDX_W-1:0]     cfg_index,
	input  logic [slew_lim_pkg::CDATA_W-1:0]    cfg_data,
	output slew_lim_pkg::cfg_t                  cfg
);
	import slew_lim_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pan_step        <= PAN_STEP_RST;
			cfg_q.tilt_step       <= TILT_STEP_RST;
			cfg_q.zoom_step       <= ZOOM_STEP_RST;
			cfg_q.angle_tolerance <= ANGLE_TOL_RST;
			cfg_q.zoom_tolerance  <= ZOOM_TOL_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_PAN_STEP:  cfg_q.pan_step        <= cfg_data[PSTEP_W-1:0];
				CFG_TILT_STEP: cfg_q.tilt_step       <= cfg_data[TSTEP_W-1:0];
				CFG_ZOOM_STEP: cfg_q.zoom_step       <= cfg_data[ZSTEP_W-1:0];
				CFG_ANGLE_TOL: cfg_q.angle_tolerance <= cfg_data[TOL_W-1:0];
				CFG_ZOOM_TOL:  cfg_q.zoom_tolerance  <= cfg_data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hdl/slew_lim_axis.sv
module slew_lim_axis #(
	parameter int W = 17
) (
	input  logic signed [W-1:0]              pos,
	input  logic signed [W-1:0]              goal,
	input  logic [W-1:0]                     step,
	input  logic [slew_lim_pkg::TOL_W-1:0]   tol,
	output logic signed [W-1:0]              pos_next,
	output logic                             moved,
	output logic                             near
);
	import slew_lim_pkg::*;

	logic signed [W:0] diff;
	logic [W:0]        mag;
	logic [W:0]        step_ext;
	logic [W:0]        tol_ext;
	logic [W:0]        pos_ext;
	logic [W:0]        up;
	logic [W:0]        dn;
	logic              step_br;
	logic              snap_br;

	assign diff     = {goal[W-1], goal} - {pos[W-1], pos};
	assign mag      = diff[W] ? (~unsigned'(diff) + 1'b1) : unsigned'(diff);
	assign step_ext = {1'b0, step};
	assign tol_ext  = (W+1)'(tol);
	assign pos_ext  = {pos[W-1], pos};
	assign up       = pos_ext + step_ext;
	assign dn       = pos_ext - step_ext;

	assign step_br = mag > step_ext;
	assign snap_br = !step_br && (mag > tol_ext);
	assign near    = mag <= tol_ext;
	assign moved   = step_br || snap_br;

	// step never crosses the goal, so the low bits are the new position
	always_comb begin
		if (step_br) begin
			pos_next = diff[W] ? signed'(dn[W-1:0]) : signed'(up[W-1:0]);
		end else if (snap_br) begin
			pos_next = goal;
		end else begin
			pos_next = pos;
		end
	end

endmodule

// File: hdl/slew_lim_core.sv
module slew_lim_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 commit,
	input  slew_lim_pkg::cmd_t   cmd,
	input  slew_lim_pkg::cfg_t   cfg,
	output slew_lim_pkg::res_t   res
);
	import slew_lim_pkg::*;

	logic signed [PAN_W-1:0]  pan_pos_q,  pan_goal_q,  pan_pos_d,  pan_goal_d;
	logic signed [TILT_W-1:0] tilt_pos_q, tilt_goal_q, tilt_pos_d, tilt_goal_d;
	logic [ZOOM_W-1:0]        zoom_pos_q, zoom_goal_q, zoom_pos_d, zoom_goal_d;
	logic                     active_q, active_d;

	logic signed [PAN_W-1:0]  pan_nxt;
	logic signed [TILT_W-1:0] tilt_nxt;
	logic signed [ZOOM_W:0]   zoom_nxt;
	logic                     pan_mv, tilt_mv, zoom_mv;
	logic                     pan_near, tilt_near, zoom_near;
	logic                     changed, done;

	slew_lim_axis #(.W(PAN_W)) u_pan (
		.pos      (pan_pos_q),
		.goal     (pan_goal_q),
		.step     (PAN_W'(cfg.pan_step)),
		.tol      (cfg.angle_tolerance),
		.pos_next (pan_nxt),
		.moved    (pan_mv),
		.near     (pan_near)
	);

	slew_lim_axis #(.W(TILT_W)) u_tilt (
		.pos      (tilt_pos_q),
		.goal     (tilt_goal_q),
		.step     (TILT_W'(cfg.tilt_step)),
		.tol      (cfg.angle_tolerance),
		.pos_next (tilt_nxt),
		.moved    (tilt_mv),
		.near     (tilt_near)
	);

	// zoom is unsigned; widen by one bit so it runs as a signed axis
	slew_lim_axis #(.W(ZOOM_W+1)) u_zoom (
		.pos      (signed'({1'b0, zoom_pos_q})),
		.goal     (signed'({1'b0, zoom_goal_q})),
		.step     ((ZOOM_W+1)'(cfg.zoom_step)),
		.tol      (cfg.zoom_tolerance),
		.pos_next (zoom_nxt),
		.moved    (zoom_mv),
		.near     (zoom_near)
	);

	always_comb begin
		pan_pos_d   = pan_pos_q;
		tilt_pos_d  = tilt_pos_q;
		zoom_pos_d  = zoom_pos_q;
		pan_goal_d  = pan_goal_q;
		tilt_goal_d = tilt_goal_q;
		zoom_goal_d = zoom_goal_q;
		active_d    = active_q;
		changed     = 1'b0;
		done        = 1'b0;
		unique case (op_t'(cmd.op))
			OP_TICK: begin
				if (active_q) begin
					pan_pos_d  = pan_nxt;
					tilt_pos_d = tilt_nxt;
					zoom_pos_d = zoom_nxt[ZOOM_W-1:0];
					changed    = pan_mv || tilt_mv || zoom_mv;
					// arrival is judged on the positions before this update
					if (pan_near && tilt_near && zoom_near) begin
						active_d = 1'b0;
						done     = 1'b1;
					end
				end
			end
			OP_SET_PAN: begin
				pan_goal_d = cmd.pan_target;
				active_d   = 1'b1;
			end
			OP_SET_TILT: begin
				tilt_goal_d = cmd.tilt_target;
				active_d    = 1'b1;
			end
			OP_SET_ZOOM: begin
				zoom_goal_d = cmd.zoom_target;
				active_d    = 1'b1;
			end
			OP_SET_ALL: begin
				pan_goal_d  = cmd.pan_target;
				tilt_goal_d = cmd.tilt_target;
				zoom_goal_d = cmd.zoom_target;
				active_d    = 1'b1;
			end
			OP_STOP: active_d = 1'b0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pan_pos_q   <= '0;
			tilt_pos_q  <= '0;
			zoom_pos_q  <= '0;
			pan_goal_q  <= '0;
			tilt_goal_q <= '0;
			zoom_goal_q <= '0;
			active_q    <= 1'b0;
		end else if (commit) begin
			pan_pos_q   <= pan_pos_d;
			tilt_pos_q  <= tilt_pos_d;
			zoom_pos_q  <= zoom_pos_d;
			pan_goal_q  <= pan_goal_d;
			tilt_goal_q <= tilt_goal_d;
			zoom_goal_q <= zoom_goal_d;
			active_q    <= active_d;
		end
	end

	assign res.pan_now   = pan_pos_d;
	assign res.tilt_now  = tilt_pos_d;
	assign res.zoom_now  = zoom_pos_d;
	assign res.changed   = changed;
	assign res.is_moving = active_d;
	assign res.done_res  = done;

endmodule

// File: hdl/three_axis_slew_limiter_unit.sv
// Path: an input transfer is held in the input register, then the position
// update writes its result into the output register on the master side.
// Throughput: one item per cycle unless m_axis_tready stalls the output;
// the single update stage closes the position loop, so items need not wait.
// Reset: arst_n clears positions, goals, motion flag and both valid flags;
// the step and tolerance registers return to their default values.
module three_axis_slew_limiter_unit (
	input  logic                                      clk,
	input  logic                                      arst_n,
	// pan_target[16:0], tilt_target[32:17], zoom_target[48:33], zero pad
	input  logic [slew_lim_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
	// op[2:0]
	input  logic [slew_lim_pkg::OP_W-1:0]             s_axis_tuser,
	input  logic                                      s_axis_tvalid,
	output logic                                      s_axis_tready,
	// pan_now[16:0], tilt_now[32:17], zoom_now[48:33], changed[49],
	// is_moving[50], done_res[51], zero pad
	output logic [slew_lim_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
	output logic                                      m_axis_tvalid,
	input  logic                                      m_axis_tready,
	input  logic                                      cfg_we,
	input  logic [slew_lim_pkg::CIDX_W-1:0]           cfg_index,
	input  logic [slew_lim_pkg::CDATA_W-1:0]          cfg_data
);
	import slew_lim_pkg::*;

	localparam int IN_USED  = PAN_W + TILT_W + ZOOM_W;
	localparam int OUT_USED = PAN_W + TILT_W + ZOOM_W + 3;

	cfg_t cfg;
	cmd_t cmd_s1;
	res_t res_d;
	res_t res_q;
	logic s1_valid_q;
	logic out_valid_q;
	logic advance;

	slew_lim_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// move the held item on when the output slot is free or being drained
	assign advance       = s1_valid_q && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !s1_valid_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cmd_s1.op          <= s_axis_tuser;
			cmd_s1.pan_target  <= signed'(s_axis_tdata[PAN_W-1:0]);
			cmd_s1.tilt_target <= signed'(s_axis_tdata[PAN_W+TILT_W-1:PAN_W]);
			cmd_s1.zoom_target <= s_axis_tdata[IN_USED-1:PAN_W+TILT_W];
		end
	end

	slew_lim_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (advance),
		.cmd    (cmd_s1),
		.cfg    (cfg),
		.res    (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {
		(OUT_TDATA_W-OUT_USED)'(0),
		res_q.done_res,
		res_q.is_moving,
		res_q.changed,
		res_q.zoom_now,
		res_q.tilt_now,
		res_q.pan_now
	};

endmodule

// File: hdl/slew_lim_checker.sv
module slew_lim_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   s_axis_tready,
	input logic [slew_lim_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	input logic                                   m_axis_tvalid,
	input logic                                   m_axis_tready
);
	import slew_lim_pkg::*;

	localparam int CHG_B  = PAN_W + TILT_W + ZOOM_W;
	localparam int MOV_B  = CHG_B + 1;
	localparam int DONE_B = CHG_B + 2;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed or dropped");

	// an empty output slot always lets a new item in
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output slot");

	// completion always ends motion
	a_done_stops: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[DONE_B] |-> !m_axis_tdata[MOV_B])
		else $error("done reported while still moving");

	// a moving axis without completion leaves motion active
	a_change_moving: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[CHG_B] && !m_axis_tdata[DONE_B] |->
			m_axis_tdata[MOV_B])
		else $error("axis moved while motion inactive");

endmodule

bind three_axis_slew_limiter_unit slew_lim_checker u_slew_lim_checker (.*);

// File: verif/three_axis_slew_limiter_unit_test.sv
`timescale 1ns / 1ps

module three_axis_slew_limiter_unit_test;

	import slew_lim_pkg::*;

	localparam int TILT_LSB    = PAN_W;
	localparam int ZOOM_LSB    = PAN_W + TILT_W;
	localparam int FLAG_LSB    = PAN_W + TILT_W + ZOOM_W;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 80;
	localparam int PHASE_CMDS  = 135;

	// op codes the block ignores
	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

	class slew_position_board;
		logic signed [PAN_W-1:0]  pan_pos, pan_goal;
		logic signed [TILT_W-1:0] tilt_pos, tilt_goal;
		logic [ZOOM_W-1:0]        zoom_pos, zoom_goal;
		bit                       moving;
		logic [PSTEP_W-1:0]       pan_step;
		logic [TSTEP_W-1:0]       tilt_step;
		logic [ZSTEP_W-1:0]       zoom_step;
		logic [TOL_W-1:0]         angle_tol, zoom_tol;
		res_t                     pending_positions[$];
		int                       mismatch_count;

		function new();
			pan_pos = '0;
			tilt_pos = '0;
			zoom_pos = '0;
			pan_goal = '0;
			tilt_goal = '0;
			zoom_goal = '0;
			moving = 1'b0;
			pan_step = PAN_STEP_RST;
			tilt_step = TILT_STEP_RST;
			zoom_step = ZOOM_STEP_RST;
			angle_tol = ANGLE_TOL_RST;
			zoom_tol = ZOOM_TOL_RST;
			mismatch_count = 0;
		endfunction

		function void write_register(cfg_idx_t idx, logic [CDATA_W-1:0] value);
			case (idx)
				CFG_PAN_STEP:  pan_step = value[PSTEP_W-1:0];
				CFG_TILT_STEP: tilt_step = value[TSTEP_W-1:0];
				CFG_ZOOM_STEP: zoom_step = value[ZSTEP_W-1:0];
				CFG_ANGLE_TOL: angle_tol = value[TOL_W-1:0];
				CFG_ZOOM_TOL:  zoom_tol = value[TOL_W-1:0];
				default: ;
			endcase
		endfunction

		// Step toward the goal, snap once inside one stride, hold inside tolerance.
		function bit slew_axis(input int pos, input int goal, input int stride, input int tol,
				output int moved_to);
			int diff;
			int mag;
			diff = goal - pos;
			mag = diff < 0 ? -diff : diff;
			moved_to = pos;
			if (mag > stride) begin
				moved_to = diff > 0 ? pos + stride : pos - stride;
				return 1'b1;
			end
			if (mag > tol) begin
				moved_to = goal;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function bit near(input int pos, input int goal, input int tol);
			int diff;
			diff = goal - pos;
			return (diff < 0 ? -diff : diff) <= tol;
		endfunction

		function void note_command(logic [OP_W-1:0] op, logic signed [PAN_W-1:0] pt,
				logic signed [TILT_W-1:0] tt, logic [ZOOM_W-1:0] zt);
			res_t r;
			bit   arrived;
			int   p, t, z;
			r.changed = 1'b0;
			r.done_res = 1'b0;
			case (op)
				OP_TICK: begin
					if (moving) begin
						// arrival is judged on the positions before this update
						arrived = near(pan_pos, pan_goal, angle_tol) &&
							near(tilt_pos, tilt_goal, angle_tol) &&
							near(zoom_pos, zoom_goal, zoom_tol);
						if (slew_axis(pan_pos, pan_goal, pan_step, angle_tol, p))
							r.changed = 1'b1;
						if (slew_axis(tilt_pos, tilt_goal, tilt_step, angle_tol, t))
							r.changed = 1'b1;
						if (slew_axis(zoom_pos, zoom_goal, zoom_step, zoom_tol, z))
							r.changed = 1'b1;
						pan_pos = PAN_W'(p);
						tilt_pos = TILT_W'(t);
						zoom_pos = ZOOM_W'(z);
						if (arrived) begin
							moving = 1'b0;
							r.done_res = 1'b1;
						end
					end
				end
				OP_SET_PAN: begin
					pan_goal = pt;
					moving = 1'b1;
				end
				OP_SET_TILT: begin
					tilt_goal = tt;
					moving = 1'b1;
				end
				OP_SET_ZOOM: begin
					zoom_goal = zt;
					moving = 1'b1;
				end
				OP_SET_ALL: begin
					pan_goal = pt;
					tilt_goal = tt;
					zoom_goal = zt;
					moving = 1'b1;
				end
				OP_STOP: moving = 1'b0;
				default: ;
			endcase
			r.pan_now = pan_pos;
			r.tilt_now = tilt_pos;
			r.zoom_now = zoom_pos;
			r.is_moving = moving;
			pending_positions.push_back(r);
		endfunction

		function void check_position(res_t got);
			res_t want;
			if (pending_positions.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: result with nothing pending: pan %0d tilt %0d zoom %0d",
						$realtime, got.pan_now, got.tilt_now, got.zoom_now);
				return;
			end
			want = pending_positions.pop_front();
			if (want.pan_now !== got.pan_now || want.tilt_now !== got.tilt_now ||
					want.zoom_now !== got.zoom_now || want.changed !== got.changed ||
					want.is_moving !== got.is_moving || want.done_res !== got.done_res) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("%0t: position mismatch", $realtime);
					$display("  expected pan %0d tilt %0d zoom %0d changed %b moving %b done %b",
						want.pan_now, want.tilt_now, want.zoom_now,
						want.changed, want.is_moving, want.done_res);
					$display("  actual   pan %0d tilt %0d zoom %0d changed %b moving %b done %b",
						got.pan_now, got.tilt_now, got.zoom_now,
						got.changed, got.is_moving, got.done_res);
				end
			end
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic [IN_TDATA_W-1:0]    s_axis_tdata;
	logic [OP_W-1:0]          s_axis_tuser;
	logic                     s_axis_tvalid;
	logic                     s_axis_tready;
	logic [OUT_TDATA_W-1:0]   m_axis_tdata;
	logic                     m_axis_tvalid;
	logic                     m_axis_tready;
	logic                     cfg_we;
	logic [CIDX_W-1:0]        cfg_index;
	logic [CDATA_W-1:0]       cfg_data;

	slew_position_board board = new();
	int hold_requests = 0;
	int cmds_sent = 0;
	bit calm = 1'b0;

	three_axis_slew_limiter_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// check the outgoing transfer before noting the incoming one
	always @(posedge clk) begin
		res_t got;
		if (m_axis_tvalid && m_axis_tready) begin
			got.pan_now = m_axis_tdata[TILT_LSB-1:0];
			got.tilt_now = m_axis_tdata[ZOOM_LSB-1:TILT_LSB];
			got.zoom_now = m_axis_tdata[FLAG_LSB-1:ZOOM_LSB];
			got.changed = m_axis_tdata[FLAG_LSB];
			got.is_moving = m_axis_tdata[FLAG_LSB+1];
			got.done_res = m_axis_tdata[FLAG_LSB+2];
			board.check_position(got);
		end
		if (s_axis_tvalid && s_axis_tready)
			board.note_command(s_axis_tuser, s_axis_tdata[TILT_LSB-1:0],
				s_axis_tdata[ZOOM_LSB-1:TILT_LSB], s_axis_tdata[FLAG_LSB-1:ZOOM_LSB]);
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("end of test: mismatches");
		$finish;
	end

	// receiver: random stalls, smooth stretches, and long holds on request
	initial begin
		int  stall_left;
		int  mode_left;
		int  holds_done;
		bit  smooth;
		bit  rdy;
		stall_left = 0;
		mode_left = 0;
		holds_done = 0;
		smooth = 1'b0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_done != hold_requests) begin
				holds_done++;
				stall_left = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				smooth = ($urandom_range(0, 3) == 0);
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			if (stall_left > 0) begin
				stall_left--;
				rdy = 1'b0;
			end else if (smooth || $urandom_range(0, 9) < 7) begin
				rdy = 1'b1;
			end else begin
				rdy = 1'b0;
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
					: $urandom_range(0, 2);
			end
			m_axis_tready <= rdy;
		end
	end

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic int span(int lo, int hi);
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	// target a few strides away from the current position, sometimes anywhere
	function automatic int aim(int from, int stride, int tol, int lo, int hi);
		int d;
		if ($urandom_range(0, 9) == 0)
			return span(lo, hi);
		d = int'($urandom_range(0, 6)) * stride + int'($urandom_range(0, tol + 3));
		if ($urandom_range(0, 1))
			d = -d;
		d = from + d;
		return d < lo ? lo : (d > hi ? hi : d);
	endfunction

	function automatic int settle_ticks();
		int n, d, need;
		n = 0;
		d = board.pan_goal - board.pan_pos;
		d = d < 0 ? -d : d;
		need = board.pan_step == 0 ? 2 : d / board.pan_step + 2;
		n = need > n ? need : n;
		d = board.tilt_goal - board.tilt_pos;
		d = d < 0 ? -d : d;
		need = board.tilt_step == 0 ? 2 : d / board.tilt_step + 2;
		n = need > n ? need : n;
		d = int'(board.zoom_goal) - int'(board.zoom_pos);
		d = d < 0 ? -d : d;
		need = board.zoom_step == 0 ? 2 : d / board.zoom_step + 2;
		n = need > n ? need : n;
		return n > 30 ? 30 : n;
	endfunction

	// Offer one command, hold it until the transfer, then idle for the requested gap.
	task automatic send_cmd(logic [OP_W-1:0] op, int pt, int tt, int zt, int gap);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {{(IN_TDATA_W - FLAG_LSB){1'b0}}, ZOOM_W'(zt), TILT_W'(tt), PAN_W'(pt)};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		if (op <= OP_STOP)
			cmds_sent++;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic drain_all();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (board.pending_positions.size() != 0);
	endtask

	task automatic cfg_put(cfg_idx_t idx, int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CDATA_W'(value);
		board.write_register(idx, CDATA_W'(value));
		@(negedge clk);
	endtask

	task automatic apply_settings(int ps, int ts, int zs, int at, int zt);
		drain_all();
		cfg_put(CFG_PAN_STEP, ps);
		cfg_put(CFG_TILT_STEP, ts);
		cfg_put(CFG_ZOOM_STEP, zs);
		cfg_put(CFG_ANGLE_TOL, at);
		cfg_put(CFG_ZOOM_TOL, zt);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_tick();
		send_cmd(OP_TICK, span(-36000, 36000), span(-18000, 18000), span(0, 65535), pick_gap());
	endtask

	// Mostly a set command followed by ticks until arrival; some noise and cut-offs.
	task automatic run_episode();
		logic [OP_W-1:0] op;
		int pt, tt, zt, n, k;
		calm = ($urandom_range(0, 5) == 0);
		if ($urandom_range(0, 6) == 0) begin
			op = OP_W'($urandom_range(0, 7));
			send_cmd(op, span(-36000, 36000), span(-18000, 18000), span(0, 65535), pick_gap());
			return;
		end
		for (k = 0; k < ($urandom_range(0, 3) == 0 ? 2 : 1); k++) begin
			case ($urandom_range(0, 3))
				0: op = OP_SET_PAN;
				1: op = OP_SET_TILT;
				2: op = OP_SET_ZOOM;
				default: op = OP_SET_ALL;
			endcase
			pt = aim(board.pan_pos, board.pan_step, board.angle_tol, -36000, 36000);
			tt = aim(board.tilt_pos, board.tilt_step, board.angle_tol, -18000, 18000);
			zt = aim(board.zoom_pos, board.zoom_step, board.zoom_tol, 0, 65535);
			send_cmd(op, pt, tt, zt, pick_gap());
		end
		n = settle_ticks();
		if ($urandom_range(0, 4) == 0) begin
			// cut the move short, sometimes with a stop
			n = $urandom_range(1, n);
			repeat (n) send_tick();
			if ($urandom_range(0, 1))
				send_cmd(OP_STOP, span(-36000, 36000), span(-18000, 18000), span(0, 65535),
					pick_gap());
		end else begin
			repeat (n + $urandom_range(0, 1)) send_tick();
		end
	endtask

	task automatic run_phase(int quota);
		int start;
		start = cmds_sent;
		while (cmds_sent - start < quota)
			run_episode();
	endtask

	// Hold the receiver off while commands keep coming, then wait for every result.
	task automatic back_up_output();
		hold_requests++;
		send_cmd(OP_SET_ALL, aim(board.pan_pos, board.pan_step, board.angle_tol, -36000, 36000),
			aim(board.tilt_pos, board.tilt_step, board.angle_tol, -18000, 18000),
			aim(board.zoom_pos, board.zoom_step, board.zoom_tol, 0, 65535), 0);
		repeat (23)
			send_cmd(OP_TICK, span(-36000, 36000), span(-18000, 18000), span(0, 65535), 0);
		drain_all();
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: largest strides and tolerances, full-scale targets
		apply_settings(36000, 18000, 65535, 1000, 1000);
		send_cmd(OP_TICK, 0, 0, 0, pick_gap());
		send_cmd(OP_SPARE_LO, -36000, -18000, 65535, pick_gap());
		send_cmd(OP_SPARE_HI, 36000, 18000, 0, pick_gap());
		send_cmd(OP_SET_ALL, 36000, 18000, 65535, pick_gap());
		// snap first, done lands on the following tick
		repeat (3) send_cmd(OP_TICK, 0, 0, 0, pick_gap());
		send_cmd(OP_SET_ALL, -36000, -18000, 0, pick_gap());
		repeat (3) send_cmd(OP_TICK, -1, -1, 65535, pick_gap());
		send_cmd(OP_SET_PAN, 1500, 18000, 65535, pick_gap());
		send_cmd(OP_SET_TILT, -36000, -1, 0, pick_gap());
		send_cmd(OP_SET_ZOOM, 36000, 0, 32768, pick_gap());
		send_cmd(OP_TICK, 0, 0, 0, pick_gap());
		send_cmd(OP_STOP, 0, 0, 0, pick_gap());
		send_cmd(OP_TICK, 0, 0, 0, pick_gap());
		// zero stride: axes count as changed without moving
		apply_settings(0, 0, 0, 0, 0);
		send_cmd(OP_SET_ALL, 100, -100, 100, pick_gap());
		repeat (2) send_cmd(OP_TICK, 0, 0, 0, pick_gap());
		send_cmd(OP_STOP, 0, 0, 0, pick_gap());
		send_cmd(OP_TICK, 0, 0, 0, pick_gap());

		apply_settings(100, 100, 100, 10, 10);
		run_phase(PHASE_CMDS);
		apply_settings(span(0, 36000), span(0, 18000), span(0, 65535), span(0, 1000),
			span(0, 1000));
		back_up_output();
		run_phase(PHASE_CMDS - 24);
		apply_settings(36000, 18000, 65535, 1000, 1000);
		run_phase(PHASE_CMDS);
		apply_settings(1, 1, 1, 0, 0);
		run_phase(PHASE_CMDS);
		apply_settings(span(1, 2000), span(1, 2000), span(1, 4000), span(0, 100), span(0, 100));
		run_phase(PHASE_CMDS);
		apply_settings(0, 0, 0, 1000, 1000);
		run_phase(PHASE_CMDS);
		apply_settings(span(0, 36000), span(0, 18000), span(0, 65535), 0, 0);
		run_phase(PHASE_CMDS);

		drain_all();
		repeat (4) @(posedge clk);
		if (board.mismatch_count == 0 && board.pending_positions.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
